// ===== sv/swd_host_transfer_engine_unit_assert.svh =====
// Assertion macros for the SWD host engine
`ifndef SWD_HOST_TRANSFER_ENGINE_UNIT_ASSERT_SVH
`define SWD_HOST_TRANSFER_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SWD_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SWD_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SWD_ASSERT_IMPL(label, clk, rst, a, c, msg)
`define SWD_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ===== sv/swdh_pkg.sv =====
`default_nettype none
package swdh_pkg;
  typedef struct packed {
    logic [1:0]  opcode;
    logic        ap_not_dp;
    logic        read_not_write;
    logic [1:0]  reg_word;
    logic [31:0] write_data;
    logic        recover_on_error;
    logic        line_in;
  } swdh_in_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        line_out;
    logic        line_drive;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  ack_code;
    logic [31:0] read_data;
  } swdh_out_t;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_XFER   = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;
  localparam logic [1:0] OP_SWITCH = 2'd3;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_REQ    = 4'd1;
  localparam logic [3:0] PH_TRN_A  = 4'd2;
  localparam logic [3:0] PH_ACK    = 4'd3;
  localparam logic [3:0] PH_TRN_B  = 4'd4;
  localparam logic [3:0] PH_WDATA  = 4'd5;
  localparam logic [3:0] PH_RDATA  = 4'd6;
  localparam logic [3:0] PH_TRN_C  = 4'd7;
  localparam logic [3:0] PH_RST_HI = 4'd8;
  localparam logic [3:0] PH_RST_LO = 4'd9;
  localparam logic [3:0] PH_SWITCH = 4'd10;

  localparam logic [2:0] ACK_OK   = 3'd1;
  localparam logic [2:0] ACK_WAIT = 3'd2;

  localparam logic [2:0] RS_NONE   = 3'd0;
  localparam logic [2:0] RS_ABORT  = 3'd1;
  localparam logic [2:0] RS_CSTAT  = 3'd2;
  localparam logic [2:0] RS_CLEAR  = 3'd3;
  localparam logic [2:0] RS_SWITCH = 3'd4;
  localparam logic [2:0] RS_IDCODE = 3'd5;

  localparam logic [15:0] SWITCH_SEQ = 16'hE79E;
  localparam logic       CFG_RETRY = 1'b0;
  localparam logic       CFG_RSTHI = 1'b1;

  function automatic logic [7:0] req_byte(input logic ap, input logic rnw,
                                          input logic [1:0] wd);
    req_byte = {2'b10, ap ^ rnw ^ wd[0] ^ wd[1], wd[1], wd[0], rnw, ap, 1'b1};
  endfunction
endpackage
`default_nettype wire

// ===== sv/swdh_core.sv =====
`default_nettype none
module swdh_core import swdh_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      go,
  input  wire swdh_in_t  din,
  input  wire logic [9:0] retry_limit,
  input  wire logic [7:0] reset_high_cycles,
  output swdh_out_t      dout,
  output logic [3:0]     phase_now
);
  logic [3:0]  phase, phase_next;
  logic [7:0]  bit_count, bit_count_next;
  logic [31:0] shift_word, shift_word_next;
  logic        running_parity, running_parity_next;
  logic [7:0]  request_byte, request_byte_next;
  logic [31:0] pending_write, pending_write_next;
  logic [9:0]  retries_left, retries_left_next;
  logic [2:0]  last_ack, last_ack_next;
  logic [31:0] received_word, received_word_next;
  logic [2:0]  recovery_step, recovery_step_next;
  logic [31:0] saved_ctrlstat, saved_ctrlstat_next;
  logic        recovery_enabled, recovery_enabled_next;
  logic        clk_o, lo, dr, done;
  logic [2:0]  ack;
  logic [31:0] ab;
  logic        st_go, st_ap, st_rnw;
  logic [1:0]  st_wd;
  logic [31:0] st_data;
  logic        aa_go;
  logic [2:0]  aa_ack;
  logic        fin;

  assign phase_now = phase;
  // abort clear bits come from the CTRLSTAT word that is just finishing
  assign ab = {27'd0, shift_word[1], shift_word[7], shift_word[5], 2'b00};

  always_comb begin
    phase_next = phase; bit_count_next = bit_count; shift_word_next = shift_word;
    running_parity_next = running_parity; request_byte_next = request_byte;
    pending_write_next = pending_write; retries_left_next = retries_left;
    last_ack_next = last_ack; received_word_next = received_word;
    recovery_step_next = recovery_step; saved_ctrlstat_next = saved_ctrlstat;
    recovery_enabled_next = recovery_enabled;
    clk_o = 1'b0; lo = 1'b0; dr = 1'b0; done = 1'b0;
    st_go = 1'b0; st_ap = 1'b0; st_rnw = 1'b0; st_wd = 2'd0; st_data = '0;
    aa_go = 1'b0; aa_ack = shift_word[2:0]; fin = 1'b0;
    ack = {din.line_in, shift_word[1:0]};
    if (go) begin
      if (din.opcode != OP_TICK) begin
        if (phase == PH_IDLE) begin
          recovery_step_next = RS_NONE;
          if (din.opcode == OP_XFER) begin
            recovery_enabled_next = din.recover_on_error;
            st_go = 1'b1; st_ap = din.ap_not_dp; st_rnw = din.read_not_write;
            st_wd = din.reg_word; st_data = din.write_data;
          end else begin
            phase_next = (din.opcode == OP_RESET) ? PH_RST_HI : PH_SWITCH;
            bit_count_next = '0;
          end
        end
      end else if (phase != PH_IDLE) begin
        clk_o = 1'b1;
        case (phase)
          PH_REQ: begin
            dr = 1'b1; lo = request_byte[bit_count[2:0]];
            bit_count_next = bit_count + 8'd1;
            if (bit_count_next >= 8'd8) phase_next = PH_TRN_A;
          end
          PH_TRN_A: begin
            phase_next = PH_ACK; bit_count_next = '0; shift_word_next = '0;
          end
          PH_ACK: begin
            shift_word_next = shift_word | (32'(din.line_in) << bit_count[1:0]);
            bit_count_next = bit_count + 8'd1;
            if (bit_count_next >= 8'd3) begin
              if (recovery_step == RS_NONE) last_ack_next = ack;
              if (!request_byte[2] || ack != ACK_OK) phase_next = PH_TRN_B;
              else begin aa_go = 1'b1; aa_ack = ack; end
            end
          end
          PH_TRN_B: aa_go = 1'b1;
          PH_WDATA: begin
            dr = 1'b1;
            if (bit_count < 8'd32) begin
              lo = pending_write[bit_count[4:0]];
              running_parity_next = running_parity ^ lo;
              bit_count_next = bit_count + 8'd1;
            end else begin
              lo = running_parity; fin = 1'b1;
            end
          end
          PH_RDATA: begin
            if (bit_count < 8'd32) begin
              shift_word_next = shift_word | (32'(din.line_in) << bit_count[4:0]);
              bit_count_next = bit_count + 8'd1;
            end else phase_next = PH_TRN_C;
          end
          PH_TRN_C: begin
            if (recovery_step == RS_NONE) received_word_next = shift_word;
            else if (recovery_step == RS_CSTAT) saved_ctrlstat_next = shift_word;
            fin = 1'b1;
          end
          PH_RST_HI: begin
            dr = 1'b1; lo = 1'b1;
            if (bit_count < 8'd255) bit_count_next = bit_count + 8'd1;
            if (bit_count_next >= reset_high_cycles) begin
              phase_next = PH_RST_LO; bit_count_next = '0;
            end
          end
          PH_RST_LO: begin
            dr = 1'b1; bit_count_next = bit_count + 8'd1;
            if (bit_count_next >= 8'd2) begin
              if (recovery_step == RS_SWITCH) begin
                recovery_step_next = RS_IDCODE; st_go = 1'b1; st_rnw = 1'b1;
              end else begin
                phase_next = PH_IDLE; done = 1'b1;
              end
            end
          end
          PH_SWITCH: begin
            dr = 1'b1; lo = SWITCH_SEQ[bit_count[3:0]];
            bit_count_next = bit_count + 8'd1;
            if (bit_count_next >= 8'd16) begin
              phase_next = PH_RST_HI; bit_count_next = '0;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
    // ack decision
    if (aa_go) begin
      if (aa_ack == ACK_WAIT && retries_left != '0) begin
        retries_left_next = retries_left - 10'd1;
        phase_next = PH_REQ; bit_count_next = '0;
      end else if (aa_ack != ACK_OK && recovery_step == RS_NONE && recovery_enabled) begin
        st_go = 1'b1;
        if (aa_ack == ACK_WAIT) begin
          recovery_step_next = RS_ABORT; st_data = 32'd1;
        end else begin
          recovery_step_next = RS_CSTAT; st_rnw = 1'b1; st_wd = 2'd1;
        end
      end else if (request_byte[2]) begin
        phase_next = PH_RDATA; bit_count_next = '0; shift_word_next = '0;
      end else begin
        phase_next = PH_WDATA; bit_count_next = '0; running_parity_next = 1'b0;
      end
    end
    if (fin) begin
      if (recovery_step == RS_CSTAT) begin
        recovery_step_next = RS_CLEAR; st_go = 1'b1; st_data = ab;
      end else if (recovery_step == RS_CLEAR && saved_ctrlstat[7]) begin
        recovery_step_next = RS_SWITCH; phase_next = PH_SWITCH; bit_count_next = '0;
      end else begin
        phase_next = PH_IDLE; done = 1'b1;
      end
    end
    if (st_go) begin
      request_byte_next = req_byte(st_ap, st_rnw, st_wd);
      pending_write_next = st_data;
      retries_left_next = retry_limit;
      phase_next = PH_REQ; bit_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; bit_count <= '0; shift_word <= '0; running_parity <= 1'b0;
      request_byte <= '0; pending_write <= '0; retries_left <= '0; last_ack <= '0;
      received_word <= '0; recovery_step <= RS_NONE; saved_ctrlstat <= '0;
      recovery_enabled <= 1'b0;
    end else begin
      phase <= phase_next; bit_count <= bit_count_next; shift_word <= shift_word_next;
      running_parity <= running_parity_next; request_byte <= request_byte_next;
      pending_write <= pending_write_next; retries_left <= retries_left_next;
      last_ack <= last_ack_next; received_word <= received_word_next;
      recovery_step <= recovery_step_next; saved_ctrlstat <= saved_ctrlstat_next;
      recovery_enabled <= recovery_enabled_next;
    end
  end

  always_comb begin
    dout.clock_pulse = clk_o;
    dout.line_out    = dr & lo;
    dout.line_drive  = dr;
    dout.busy_res    = (phase_next != PH_IDLE);
    dout.done_res    = done;
    dout.ack_code    = last_ack_next;
    dout.read_data   = received_word_next;
  end
endmodule
`default_nettype wire

// ===== sv/swd_host_transfer_engine_unit.sv =====
`default_nettype none
// Channel | direction | handshake       | word
// in      | sink      | in_valid/stall  | swdh_in_t command or tick
// out     | source    | out_valid/stall | swdh_out_t one result per input word
// cfg     | sink      | valid/ready     | index 0 retry_limit, 1 reset_high_cycles
//
// One word per cycle while in_stall is low: the engine state updates from
// the accepted input word; each input word yields exactly one output word.
// Output register with a one-entry skid: in stall rises only when the skid
// holds a word, so the input is not stalled during a single output stall.
// Synchronous active-high reset; no memory clearing pass.
`include "swd_host_transfer_engine_unit_assert.svh"
module swd_host_transfer_engine_unit import swdh_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire swdh_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output swdh_out_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [9:0] retry_limit;
  logic [7:0] reset_high_cycles;
  logic       go;
  swdh_out_t  res;
  logic [3:0] phase_now;
  swdh_out_t  skid;
  logic       skid_valid;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= 10'd600; reset_high_cycles <= 8'd50;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RETRY) retry_limit <= cfg_data[9:0];
      else reset_high_cycles <= cfg_data[7:0];
    end
  end

  assign in_stall = skid_valid;
  assign go = in_valid & ~in_stall;

  swdh_core u_core (
    .clk(clk), .rst(rst), .go(go), .din(in_data),
    .retry_limit(retry_limit), .reset_high_cycles(reset_high_cycles),
    .dout(res), .phase_now(phase_now)
  );

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid <= 1'b1; skid_valid <= 1'b0;
        end else out_valid <= go;
      end else if (go) skid_valid <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid : res;
    end else if (go) skid <= res;
  end

  `SWD_ASSERT_IMPL(a_skid_needs_out, clk, rst, skid_valid, out_valid, "skid without out")
  `SWD_ASSERT_NEXT(a_idle_tick, clk, rst, go && phase_now == PH_IDLE && in_data.opcode == OP_TICK, !skid_valid || $past(skid_valid) || out_valid, "idle tick lost")
  `SWD_ASSERT_IMPL(a_no_go_stalled, clk, rst, skid_valid, !go, "accept while skid full")
endmodule
`default_nettype wire

// ===== tb/swd_host_checker.sv =====
`default_nettype none
// Watches the in, out and cfg channels of the SWD host engine. It predicts one
// result word per accepted input word and compares the results in order.
module swd_host_checker import swdh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire swdh_in_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire swdh_out_t   out_data,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               checked
);

  // register copies
  logic [9:0]  retry_lim;
  logic [7:0]  high_len;
  // engine state
  logic [3:0]  phase;
  logic [7:0]  cnt;
  logic [31:0] shreg;
  logic        wpar;
  logic [7:0]  req;
  logic [31:0] wword;
  logic [9:0]  tries;
  logic [2:0]  ack_last;
  logic [31:0] rword;
  logic [2:0]  rstep;
  logic [31:0] cstat;
  logic        rec_en;

  swdh_out_t expected_q[$];

  initial begin
    errors = 0;
    checked = 0;
  end
  assign pending = expected_q.size();

  function automatic void begin_xfer(logic ap, logic rnw, logic [1:0] wd,
                                     logic [31:0] data);
    req = {1'b1, 1'b0, ap ^ rnw ^ wd[0] ^ wd[1], wd[1], wd[0], rnw, ap, 1'b1};
    wword = data;
    tries = retry_lim;
    phase = PH_REQ;
    cnt = '0;
  endfunction

  function automatic void on_ack(logic [2:0] ack);
    if (ack == ACK_WAIT && tries != '0) begin
      tries = tries - 10'd1;
      phase = PH_REQ;
      cnt = '0;
    end else if (ack != ACK_OK && rstep == RS_NONE && rec_en) begin
      if (ack == ACK_WAIT) begin
        rstep = RS_ABORT;
        begin_xfer(1'b0, 1'b0, 2'd0, 32'h1);      // DAPABORT
      end else begin
        rstep = RS_CSTAT;
        begin_xfer(1'b0, 1'b1, 2'd1, 32'h0);      // read CTRL/STAT
      end
    end else if (req[2]) begin
      phase = PH_RDATA;
      cnt = '0;
      shreg = '0;
    end else begin
      phase = PH_WDATA;
      cnt = '0;
      wpar = 1'b0;
    end
  endfunction

  function automatic logic end_xfer();
    logic [31:0] clr;
    if (rstep == RS_CSTAT) begin
      clr = '0;
      if (cstat[5]) clr[2] = 1'b1;
      if (cstat[7]) clr[3] = 1'b1;
      if (cstat[1]) clr[4] = 1'b1;
      rstep = RS_CLEAR;
      begin_xfer(1'b0, 1'b0, 2'd0, clr);
      return 1'b0;
    end
    if (rstep == RS_CLEAR && cstat[7]) begin
      rstep = RS_SWITCH;
      phase = PH_SWITCH;
      cnt = '0;
      return 1'b0;
    end
    phase = PH_IDLE;
    return 1'b1;
  endfunction

  // one SWCLK cycle; returns 1 when the operation completes
  function automatic logic swclk_cycle(logic line, output logic lo, output logic dr);
    logic [2:0] ack;
    lo = 1'b0;
    dr = 1'b0;
    case (phase)
      PH_REQ: begin
        dr = 1'b1;
        lo = req[cnt[2:0]];
        cnt = cnt + 8'd1;
        if (cnt >= 8'd8) phase = PH_TRN_A;
      end
      PH_TRN_A: begin
        phase = PH_ACK;
        cnt = '0;
        shreg = '0;
      end
      PH_ACK: begin
        shreg = shreg | (32'(line) << cnt[1:0]);
        cnt = cnt + 8'd1;
        if (cnt >= 8'd3) begin
          ack = shreg[2:0];
          if (rstep == RS_NONE) ack_last = ack;
          if (!req[2] || ack != ACK_OK) phase = PH_TRN_B;
          else on_ack(ack);
        end
      end
      PH_TRN_B: on_ack(shreg[2:0]);
      PH_WDATA: begin
        dr = 1'b1;
        if (cnt < 8'd32) begin
          lo = wword[cnt[4:0]];
          wpar = wpar ^ lo;
          cnt = cnt + 8'd1;
        end else begin
          lo = wpar;
          return end_xfer();
        end
      end
      PH_RDATA: begin
        if (cnt < 8'd32) begin
          shreg = shreg | (32'(line) << cnt[4:0]);
          cnt = cnt + 8'd1;
        end else begin
          phase = PH_TRN_C;
        end
      end
      PH_TRN_C: begin
        if (rstep == RS_NONE) rword = shreg;
        else if (rstep == RS_CSTAT) cstat = shreg;
        return end_xfer();
      end
      PH_RST_HI: begin
        dr = 1'b1;
        lo = 1'b1;
        if (cnt < 8'd255) cnt = cnt + 8'd1;
        if (cnt >= high_len) begin
          phase = PH_RST_LO;
          cnt = '0;
        end
      end
      PH_RST_LO: begin
        dr = 1'b1;
        cnt = cnt + 8'd1;
        if (cnt >= 8'd2) begin
          if (rstep == RS_SWITCH) begin
            rstep = RS_IDCODE;
            begin_xfer(1'b0, 1'b1, 2'd0, 32'h0);
            return 1'b0;
          end
          phase = PH_IDLE;
          return 1'b1;
        end
      end
      PH_SWITCH: begin
        dr = 1'b1;
        lo = SWITCH_SEQ[cnt[3:0]];
        cnt = cnt + 8'd1;
        if (cnt >= 8'd16) begin
          phase = PH_RST_HI;
          cnt = '0;
        end
      end
      default: phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic swdh_out_t predict_word(swdh_in_t w);
    swdh_out_t r;
    logic lo, dr, fin;
    r = '0;
    lo = 1'b0;
    dr = 1'b0;
    fin = 1'b0;
    if (w.opcode != OP_TICK) begin
      if (phase == PH_IDLE) begin
        rstep = RS_NONE;
        if (w.opcode == OP_XFER) begin
          rec_en = w.recover_on_error;
          begin_xfer(w.ap_not_dp, w.read_not_write, w.reg_word, w.write_data);
        end else begin
          phase = (w.opcode == OP_RESET) ? PH_RST_HI : PH_SWITCH;
          cnt = '0;
        end
      end
    end else if (phase != PH_IDLE) begin
      r.clock_pulse = 1'b1;
      fin = swclk_cycle(w.line_in, lo, dr);
    end
    r.line_out = dr & lo;
    r.line_drive = dr;
    r.busy_res = (phase != PH_IDLE);
    r.done_res = fin;
    r.ack_code = ack_last;
    r.read_data = rword;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("[%0t] MISMATCH %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    swdh_out_t e;
    if (rst) begin
      retry_lim = 10'd600;
      high_len = 8'd50;
      phase = PH_IDLE;
      cnt = '0; shreg = '0; wpar = 1'b0; req = '0; wword = '0; tries = '0;
      ack_last = '0; rword = '0; rstep = RS_NONE; cstat = '0; rec_en = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RETRY) retry_lim = cfg_data[9:0];
        else high_len = cfg_data[7:0];
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_word(in_data));
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_q.size() == 0) begin
          report("unexpected word", 0, out_data.read_data);
        end else begin
          e = expected_q.pop_front();
          if (out_data.clock_pulse !== e.clock_pulse)
            report("clock_pulse", e.clock_pulse, out_data.clock_pulse);
          if (out_data.line_out !== e.line_out)
            report("line_out", e.line_out, out_data.line_out);
          if (out_data.line_drive !== e.line_drive)
            report("line_drive", e.line_drive, out_data.line_drive);
          if (out_data.busy_res !== e.busy_res)
            report("busy_res", e.busy_res, out_data.busy_res);
          if (out_data.done_res !== e.done_res)
            report("done_res", e.done_res, out_data.done_res);
          if (out_data.ack_code !== e.ack_code)
            report("ack_code", e.ack_code, out_data.ack_code);
          if (out_data.read_data !== e.read_data)
            report("read_data", e.read_data, out_data.read_data);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// Stimulus and verdict for the SWD host engine. A checker beside the block
// does all the prediction; this module only feeds words and watches time.
module tb_top;
  import swdh_pkg::*;

  localparam int ITEM_GOAL = 1050;
  localparam int IDLE_LIMIT = 5000;   // cycles with no handshake at all
  localparam int HOLD_LEN = 200;      // long receiver hold-off

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  swdh_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1;
  swdh_out_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [31:0] cfg_data = 0;

  int  errors, pending, checked;
  int  words_sent = 0;
  int  ops_run = 0;
  int  cfg_writes = 0;
  int  idle_cycles = 0;
  bit  burst_tx = 0;      // sender runs without gaps
  bit  burst_rx = 0;      // receiver runs without stalls
  bit  hold_req = 0;      // asks the receiver for one long hold-off

  always #5 clk = ~clk;

  swd_host_transfer_engine_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  swd_host_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  // Watchdog: any cycle without a handshake on any channel counts.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall before each word, one long hold when asked.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = burst_rx ? 0 : $urandom_range(0, 13);
      if (hold_req) begin
        n = HOLD_LEN;
        hold_req = 0;
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1;
      end
      @(negedge clk);
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // One word into the in channel, after a random gap.
  task automatic send_word(swdh_in_t w);
    int gap;
    gap = burst_tx ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_sent++;
  endtask

  // Let everything drain, then let the engine settle before a register write.
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 0;
    cfg_writes++;
  endtask

  // One operation: the command word, then SWCLK ticks. For transfers the ack
  // slots of each attempt carry WAIT for the first n_wait attempts and then
  // last_ack; every other line_in bit is random.
  task automatic run_op(logic [1:0] op, logic ap, logic rnw, logic [1:0] wd,
                        logic [31:0] data, logic rec, int n_wait,
                        logic [2:0] last_ack, int n_ticks);
    swdh_in_t w;
    int attempt, slot;
    logic [2:0] ackv;
    w = '0;
    w.opcode = op;
    w.ap_not_dp = ap;
    w.read_not_write = rnw;
    w.reg_word = wd;
    w.write_data = data;
    w.recover_on_error = rec;
    w.line_in = $urandom_range(0, 1);
    send_word(w);
    for (int k = 0; k < n_ticks; k++) begin
      w = '0;
      w.opcode = OP_TICK;
      w.write_data = $urandom;
      w.ap_not_dp = $urandom_range(0, 1);
      w.read_not_write = $urandom_range(0, 1);
      w.reg_word = $urandom_range(0, 3);
      w.recover_on_error = $urandom_range(0, 1);
      w.line_in = $urandom_range(0, 1);
      attempt = k / 13;
      slot = k % 13;
      if (op == OP_XFER && slot >= 9 && slot <= 11 && attempt <= n_wait) begin
        ackv = (attempt < n_wait) ? ACK_WAIT : last_ack;
        w.line_in = ackv[slot - 9];
      end
      send_word(w);
    end
    ops_run++;
  endtask

  function automatic logic [2:0] pick_ack();
    case ($urandom_range(0, 5))
      0, 1:    return ACK_OK;
      2:       return ACK_WAIT;
      3:       return 3'b100;            // FAULT
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin
    int r;
    bit did_hold;
    did_hold = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: register extremes, every opcode, OK, WAIT, FAULT and an invalid ack, recovery paths.
    write_reg(CFG_RETRY, 0);
    write_reg(CFG_RSTHI, 0);                              // zero acts as one
    run_op(OP_XFER, 0, 0, 2'd0, 32'h0, 0, 0, ACK_OK, 50);
    run_op(OP_XFER, 1, 1, 2'd3, 32'hFFFF_FFFF, 0, 0, ACK_OK, 50);
    run_op(OP_XFER, 1, 0, 2'd2, 32'hFFFF_FFFF, 1, 0, ACK_WAIT, 60);
    run_op(OP_XFER, 0, 1, 2'd1, 32'h0, 1, 0, 3'b100, 140);  // fault recovery
    run_op(OP_XFER, 0, 1, 2'd1, 32'hA5A5_5A5A, 0, 0, 3'b111, 60);
    run_op(OP_RESET, 0, 0, 2'd0, 0, 0, 0, ACK_OK, 6);
    run_op(OP_SWITCH, 0, 0, 2'd0, 0, 0, 0, ACK_OK, 24);
    write_reg(CFG_RETRY, 1023);
    write_reg(CFG_RSTHI, 255);
    run_op(OP_XFER, 1, 1, 2'd0, 32'h1234_5678, 0, 3, ACK_OK, 90);
    run_op(OP_RESET, 0, 0, 2'd0, 0, 0, 0, ACK_OK, 262);
    write_reg(CFG_RSTHI, 1);
    write_reg(CFG_RETRY, 2);
    run_op(OP_XFER, 0, 0, 2'd3, 32'hDEAD_BEEF, 1, 3, ACK_WAIT, 80); // retries run out
    // command while busy is ignored
    run_op(OP_XFER, 0, 1, 2'd1, 32'h0, 0, 0, ACK_OK, 3);
    run_op(OP_RESET, 0, 0, 2'd0, 0, 0, 0, ACK_OK, 60);

    // Random part: well-formed operations with random content, some noise.
    while (words_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 3);
        if (r == 0) write_reg(CFG_RETRY, $urandom_range(0, 4));
        else if (r == 1) write_reg(CFG_RETRY, $urandom_range(0, 1) ? 0 : 1023);
        else if (r == 2) write_reg(CFG_RSTHI, $urandom_range(0, 8));
        else write_reg(CFG_RSTHI, $urandom_range(0, 1) ? 1 : 255);
      end
      burst_tx = ($urandom_range(0, 3) == 0);
      burst_rx = ($urandom_range(0, 3) == 0);
      if (!did_hold && words_sent > ITEM_GOAL / 2) begin
        // receiver stops while the sender keeps going: the block backs up
        hold_req = 1;
        burst_tx = 1;
        did_hold = 1;
      end
      r = $urandom_range(0, 9);
      if (r < 7)
        run_op(OP_XFER, $urandom_range(0, 1), $urandom_range(0, 1),
               $urandom_range(0, 3), $urandom, $urandom_range(0, 1),
               $urandom_range(0, 3), pick_ack(), $urandom_range(30, 130));
      else if (r == 7)
        run_op(OP_RESET, 0, 0, 2'd0, 0, 0, 0, ACK_OK, $urandom_range(4, 40));
      else if (r == 8)
        run_op(OP_SWITCH, 0, 0, 2'd0, 0, 0, 0, ACK_OK, $urandom_range(10, 50));
      else
        run_op(2'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom_range(0, 1),
               $urandom_range(0, 3), $urandom, $urandom_range(0, 1), 0,
               3'($urandom_range(0, 7)), $urandom_range(0, 8));
      if (ops_run % 17 == 0) drain();     // sender waits for every result
    end

    burst_tx = 0;
    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d operations, %0d input words, %0d results checked,",
             ops_run, words_sent, checked);
    $display("%0d register writes including both extremes of each register.", cfg_writes);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== swd_host_transfer_engine_unit.f =====
+incdir+sv
sv/swdh_pkg.sv
sv/swdh_core.sv
sv/swd_host_transfer_engine_unit.sv
tb/swd_host_checker.sv
tb/tb_top.sv
